// ===== hw/rtl/salb_pkg.sv =====
// Shared types and constants of the slot allocator with live bitmap.
package salb_pkg;

	localparam int ADDR_W   = 48;
	localparam int OP_W     = 2;
	localparam int SIZE_W   = 32;
	localparam int STATUS_W = 3;
	localparam int LCOUNT_W = 12;
	localparam int BCOUNT_W = 5;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
	localparam logic [OP_W-1:0] OP_CONTAINS = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NULL    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BIG     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTSLOT = 3'd4;

	// Length of the controller's wait for the address decoder after the decide state.
	localparam int LOC_CYCLES = 6;
	localparam int LOC_CNT_W  = 3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                load;
		logic                sweep;
		logic                pop;
		logic                free_push;
		logic                report_live;
		logic                finish;
		logic [STATUS_W-1:0] code;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            size_zero;
		logic            size_big;
		logic            addr_null;
		logic            list_empty;
		logic            full;
		logic            sweep_last;
		logic            loc_ok;
	} stat_t;

endpackage

// ===== hw/rtl/slot_allocator_live_bitmap_top.sv =====
// Top level of the slot allocator with live bitmap.
//
// Requests (operation, address, request_size) are taken at a clock edge with
// start high and busy low. Each request gives one result on status,
// slot_address, is_live, live_count and blocks_committed, marked by done for
// exactly one cycle; the receiver cannot hold results off.
// Allocate pops a slot from the free list; when the list is empty, a new block is
// committed first: the commit writes the block's links into the link store one
// slot a cycle. Free and contains wait for the address decoder pipeline that
// divides the offset by the block and slot sizes with reciprocal multiplies.
// Requests rejected by size, null or full checks finish from the decide state.
// busy drops in the cycle done rises, so a new request can be transferred then.
// After reset the block commits the first block, holding busy high meanwhile.
// The region base is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module slot_allocator_live_bitmap_top #(
	parameter int SLOT_BYTES     = 32,
	parameter int BLOCK_BYTES    = 4096,
	parameter int SLOTS_IN_BLOCK = 128,
	parameter int MAX_BLOCKS     = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [salb_pkg::OP_W-1:0]         operation,
	input  logic [salb_pkg::ADDR_W-1:0]       address,
	input  logic [salb_pkg::SIZE_W-1:0]       request_size,
	input  logic                              cfg_we,
	input  logic [salb_pkg::ADDR_W-1:0]       cfg_wdata,
	output logic                              done,
	output logic [salb_pkg::STATUS_W-1:0]     status,
	output logic [salb_pkg::ADDR_W-1:0]       slot_address,
	output logic                              is_live,
	output logic [salb_pkg::LCOUNT_W-1:0]     live_count,
	output logic [salb_pkg::BCOUNT_W-1:0]     blocks_committed
);

	salb_pkg::cmd_t  cmd;
	salb_pkg::stat_t stat;

	// Sequencing of each request.
	salb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Storage and arithmetic.
	salb_dpath #(
		.SLOT_BYTES     (SLOT_BYTES),
		.BLOCK_BYTES    (BLOCK_BYTES),
		.SLOTS_IN_BLOCK (SLOTS_IN_BLOCK),
		.MAX_BLOCKS     (MAX_BLOCKS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.operation        (operation),
		.address          (address),
		.request_size     (request_size),
		.done             (done),
		.status           (status),
		.slot_address     (slot_address),
		.is_live          (is_live),
		.live_count       (live_count),
		.blocks_committed (blocks_committed)
	);

endmodule

// ===== hw/rtl/salb_ctrl.sv =====
// Controller state machine of the slot allocator.
module salb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  salb_pkg::stat_t stat,
	output salb_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SWEEP  = 3'd3;
	localparam logic [2:0] S_READ   = 3'd4;
	localparam logic [2:0] S_POP    = 3'd5;
	localparam logic [2:0] S_LOC    = 3'd6;
	localparam logic [2:0] S_APPLY  = 3'd7;

	localparam logic [salb_pkg::LOC_CNT_W-1:0] LOC_LAST =
		salb_pkg::LOC_CNT_W'(salb_pkg::LOC_CYCLES - 1);

	logic [2:0]                     state_q;
	logic [2:0]                     state_d;
	logic [salb_pkg::LOC_CNT_W-1:0] loc_cnt_q;

	assign busy = (state_q != S_IDLE);

	// Next state and commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				unique case (stat.op)
					salb_pkg::OP_ALLOC: begin
						priority if (stat.size_zero) begin
							cmd.finish = 1'b1;
							cmd.code   = salb_pkg::ST_NULL;
							state_d    = S_IDLE;
						end else if (stat.size_big) begin
							cmd.finish = 1'b1;
							cmd.code   = salb_pkg::ST_BIG;
							state_d    = S_IDLE;
						end else if (stat.full) begin
							cmd.finish = 1'b1;
							cmd.code   = salb_pkg::ST_FULL;
							state_d    = S_IDLE;
						end else if (stat.list_empty) begin
							state_d = S_SWEEP;
						end else begin
							state_d = S_READ;
						end
					end
					salb_pkg::OP_FREE: begin
						priority if (stat.addr_null || stat.size_zero) begin
							cmd.finish = 1'b1;
							cmd.code   = salb_pkg::ST_NULL;
							state_d    = S_IDLE;
						end else if (stat.size_big) begin
							cmd.finish = 1'b1;
							cmd.code   = salb_pkg::ST_BIG;
							state_d    = S_IDLE;
						end else begin
							state_d = S_LOC;
						end
					end
					salb_pkg::OP_CONTAINS: begin
						state_d = S_LOC;
					end
					default: begin
						cmd.finish = 1'b1;
						cmd.code   = salb_pkg::ST_OK;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_POP;
			end
			S_POP: begin
				cmd.pop    = 1'b1;
				cmd.finish = 1'b1;
				cmd.code   = salb_pkg::ST_OK;
				state_d    = S_IDLE;
			end
			S_LOC: begin
				if (loc_cnt_q == LOC_LAST) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
				if (!stat.loc_ok) begin
					cmd.code = salb_pkg::ST_NOTSLOT;
				end else if (stat.op == salb_pkg::OP_FREE) begin
					cmd.code      = salb_pkg::ST_OK;
					cmd.free_push = 1'b1;
				end else begin
					cmd.code        = salb_pkg::ST_OK;
					cmd.report_live = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register and decoder wait counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			loc_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_LOC) begin
				loc_cnt_q <= loc_cnt_q + 1'b1;
			end else begin
				loc_cnt_q <= '0;
			end
		end
	end

endmodule

// ===== hw/rtl/salb_dpath.sv =====
// Datapath of the slot allocator: free list store, live bitmap, address decoder.
module salb_dpath #(
	parameter int SLOT_BYTES     = 32,
	parameter int BLOCK_BYTES    = 4096,
	parameter int SLOTS_IN_BLOCK = 128,
	parameter int MAX_BLOCKS     = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  salb_pkg::cmd_t                    cmd,
	output salb_pkg::stat_t                   stat,
	input  logic                              cfg_we,
	input  logic [salb_pkg::ADDR_W-1:0]       cfg_wdata,
	input  logic [salb_pkg::OP_W-1:0]         operation,
	input  logic [salb_pkg::ADDR_W-1:0]       address,
	input  logic [salb_pkg::SIZE_W-1:0]       request_size,
	output logic                              done,
	output logic [salb_pkg::STATUS_W-1:0]     status,
	output logic [salb_pkg::ADDR_W-1:0]       slot_address,
	output logic                              is_live,
	output logic [salb_pkg::LCOUNT_W-1:0]     live_count,
	output logic [salb_pkg::BCOUNT_W-1:0]     blocks_committed
);

	localparam int AW        = salb_pkg::ADDR_W;
	localparam int SW        = $clog2(SLOTS_IN_BLOCK > 1 ? SLOTS_IN_BLOCK : 2);
	localparam int BW        = $clog2(MAX_BLOCKS > 1 ? MAX_BLOCKS : 2);
	localparam int CW        = $clog2(MAX_BLOCKS + 1);
	localparam int TOTAL     = MAX_BLOCKS * SLOTS_IN_BLOCK;
	localparam int FW        = $clog2(TOTAL > 1 ? TOTAL : 2);
	localparam int LE_W      = 1 + BW + SW;
	localparam int WPB       = (SLOTS_IN_BLOCK + 63) / 64;
	localparam int MAP_WORDS = MAX_BLOCKS * WPB;
	localparam int WW        = $clog2(MAP_WORDS > 1 ? MAP_WORDS : 2);
	localparam int LTW       = $clog2(TOTAL + 1);
	localparam int OW        = $clog2(MAX_BLOCKS * BLOCK_BYTES);
	localparam int RECIP     = (1 << OW) / BLOCK_BYTES;
	localparam int RW        = $clog2(RECIP + 1);
	localparam int PW        = OW + RW;
	localparam int BOW       = $clog2(BLOCK_BYTES);
	localparam int RECIP2    = (1 << BOW) / SLOT_BYTES;
	localparam int RW2       = $clog2(RECIP2 + 1);
	localparam int PW2       = BOW + RW2;
	localparam int SPAN      = SLOTS_IN_BLOCK * SLOT_BYTES;

	// Flat index of a slot in the link store.
	function automatic logic [FW-1:0] flat_idx(input logic [BW-1:0] blk,
		input logic [SW-1:0] slot);
		return FW'(FW'(blk) * FW'(SLOTS_IN_BLOCK) + FW'(slot));
	endfunction

	// Latched request and configuration.
	logic [salb_pkg::OP_W-1:0]   op_q;
	logic [AW-1:0]               addr_q;
	logic [salb_pkg::SIZE_W-1:0] size_q;
	logic [AW-1:0]               base_q;

	// Free list head and counters.
	logic [BW-1:0]  top_blk_q;
	logic [SW-1:0]  top_slot_q;
	logic           empty_q;
	logic [CW-1:0]  committed_q;
	logic [LTW-1:0] live_total_q;
	logic [SW-1:0]  sw_cnt_q;
	logic           sweep_last;

	// Link store.
	logic [LE_W-1:0] link_mem [TOTAL];
	logic [LE_W-1:0] rd_data_q;
	logic            mem_we;
	logic [FW-1:0]   mem_wa;
	logic [LE_W-1:0] mem_wd;

	// Live bitmap.
	logic [63:0]   live_map_q [MAP_WORDS];
	logic [BW-1:0] sel_blk;
	logic [SW-1:0] sel_slot;
	logic [WW-1:0] widx;
	logic [5:0]    bidx;
	logic          cur_bit;

	// Address decoder pipeline.
	logic [AW-1:0]  off_s1;
	logic [PW-1:0]  prod_s2;
	logic           inrng_s2;
	logic [OW-1:0]  q_c;
	logic [OW-1:0]  q_s3;
	logic [OW-1:0]  rem_s3;
	logic [OW-1:0]  blk_s4;
	logic [BOW-1:0] bo_s4;
	logic [PW2-1:0] sprod_s5;
	logic [BOW-1:0] sq_c;
	logic [BOW-1:0] sq_s6;
	logic [BOW-1:0] srem_s6;
	logic           scorr;
	logic [SW-1:0]  slot_s7;
	logic           ok_s7;
	logic [BW-1:0]  loc_blk;
	logic [SW-1:0]  loc_slot;

	// Result registers.
	logic                          done_q;
	logic [salb_pkg::STATUS_W-1:0] status_q;
	logic [AW-1:0]                 slot_addr_q;
	logic                          is_live_q;
	logic [AW-1:0]                 pop_addr;

	assign sweep_last = (sw_cnt_q == SW'(SLOTS_IN_BLOCK - 1));
	assign loc_blk    = BW'(blk_s4);
	assign loc_slot   = slot_s7;

	// Status toward the controller.
	always_comb begin
		stat            = '0;
		stat.op         = op_q;
		stat.size_zero  = (size_q == '0);
		stat.size_big   = (size_q > salb_pkg::SIZE_W'(SLOT_BYTES));
		stat.addr_null  = (addr_q == '0);
		stat.list_empty = empty_q;
		stat.full       = empty_q && (committed_q >= CW'(MAX_BLOCKS));
		stat.sweep_last = sweep_last;
		stat.loc_ok     = ok_s7;
	end

	// Link store write port: block commit sweep or push of a freed slot.
	always_comb begin
		mem_we = cmd.sweep || cmd.free_push;
		if (cmd.sweep) begin
			mem_wa = flat_idx(committed_q[BW-1:0], sw_cnt_q);
			if (sw_cnt_q == '0) begin
				mem_wd = {1'b1, top_blk_q, top_slot_q};
			end else begin
				mem_wd = {1'b0, committed_q[BW-1:0], SW'(sw_cnt_q - 1'b1)};
			end
		end else begin
			mem_wa = flat_idx(loc_blk, loc_slot);
			mem_wd = {empty_q, top_blk_q, top_slot_q};
		end
	end

	// The link of the list head is read every cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= link_mem[flat_idx(top_blk_q, top_slot_q)];
	end

	// Bitmap word and bit of the slot being popped or located.
	always_comb begin
		sel_blk  = cmd.pop ? top_blk_q : loc_blk;
		sel_slot = cmd.pop ? top_slot_q : loc_slot;
		widx     = WW'(WW'(sel_blk) * WW'(WPB) + WW'(sel_slot >> 6));
		bidx     = 6'(sel_slot);
		cur_bit  = live_map_q[widx][bidx];
	end

	assign pop_addr = AW'(base_q + AW'(top_blk_q) * AW'(BLOCK_BYTES)
		+ AW'(top_slot_q) * AW'(SLOT_BYTES));

	// Request latch and decoder stages; the request is held while they settle.
	assign q_c   = OW'(prod_s2 >> OW);
	assign sq_c  = BOW'(sprod_s5 >> BOW);
	assign scorr = ((BOW + 1)'(srem_s6) >= (BOW + 1)'(SLOT_BYTES));
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			addr_q <= address;
			size_q <= request_size;
		end
		off_s1   <= AW'(addr_q - base_q);
		inrng_s2 <= (off_s1 < AW'(AW'(committed_q) * AW'(BLOCK_BYTES)));
		prod_s2  <= PW'(PW'(off_s1[OW-1:0]) * PW'(RECIP));
		q_s3     <= q_c;
		rem_s3   <= OW'(off_s1[OW-1:0] - OW'(q_c * OW'(BLOCK_BYTES)));
		if ((OW + 1)'(rem_s3) >= (OW + 1)'(BLOCK_BYTES)) begin
			blk_s4 <= OW'(q_s3 + 1'b1);
			bo_s4  <= BOW'((OW + 1)'(rem_s3) - (OW + 1)'(BLOCK_BYTES));
		end else begin
			blk_s4 <= q_s3;
			bo_s4  <= BOW'(rem_s3);
		end
		sprod_s5 <= PW2'(PW2'(bo_s4) * PW2'(RECIP2));
		sq_s6    <= sq_c;
		srem_s6  <= BOW'(bo_s4 - BOW'(sq_c * BOW'(SLOT_BYTES)));
		slot_s7  <= SW'(scorr ? BOW'(sq_s6 + 1'b1) : sq_s6);
		ok_s7    <= inrng_s2 && (32'(bo_s4) < 32'(SPAN))
			&& (scorr ? ((BOW + 1)'(srem_s6) == (BOW + 1)'(SLOT_BYTES))
			          : (srem_s6 == '0));
	end

	// Free list head, counters, bitmap and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			top_blk_q    <= '0;
			top_slot_q   <= '0;
			empty_q      <= 1'b1;
			committed_q  <= '0;
			live_total_q <= '0;
			sw_cnt_q     <= '0;
			for (int i = 0; i < MAP_WORDS; i++) begin
				live_map_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			// Commit sweep; its last slot becomes the list head.
			if (cmd.sweep) begin
				if (sweep_last) begin
					sw_cnt_q    <= '0;
					top_blk_q   <= committed_q[BW-1:0];
					top_slot_q  <= sw_cnt_q;
					empty_q     <= 1'b0;
					committed_q <= CW'(committed_q + 1'b1);
				end else begin
					sw_cnt_q <= SW'(sw_cnt_q + 1'b1);
				end
			end
			// Pop the head and mark it live.
			if (cmd.pop) begin
				top_blk_q  <= rd_data_q[BW+SW-1:SW];
				top_slot_q <= rd_data_q[SW-1:0];
				empty_q    <= rd_data_q[LE_W-1];
				if (!cur_bit) begin
					live_map_q[widx][bidx] <= 1'b1;
					live_total_q           <= LTW'(live_total_q + 1'b1);
				end
			end
			// Push a freed slot and clear its live bit.
			if (cmd.free_push) begin
				top_blk_q  <= loc_blk;
				top_slot_q <= loc_slot;
				empty_q    <= 1'b0;
				if (cur_bit) begin
					live_map_q[widx][bidx] <= 1'b0;
					live_total_q           <= LTW'(live_total_q - 1'b1);
				end
			end
		end
	end

	// Result registers; the strobe lasts one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q    <= cmd.code;
			slot_addr_q <= cmd.pop ? pop_addr : '0;
			is_live_q   <= cmd.report_live ? cur_bit : 1'b0;
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign slot_address     = slot_addr_q;
	assign is_live          = is_live_q;
	assign live_count       = salb_pkg::LCOUNT_W'(live_total_q);
	assign blocks_committed = salb_pkg::BCOUNT_W'(committed_q);

`ifndef NO_ASSERTIONS
	a_done_follows_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> done_q)
		else $error("result strobe missing after finish");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !empty_q)
		else $error("pop from an empty free list");
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(live_total_q) <= 32'(TOTAL))
		else $error("live count exceeds slot count");
	a_commit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> (committed_q < CW'(MAX_BLOCKS)))
		else $error("block commit beyond region");
	a_push_located: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.free_push |-> ok_s7)
		else $error("push of an address that is not a slot");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the slot allocator with live bitmap.
`timescale 1ns / 100ps

module testbench;

	localparam int SLOT_B   = 32;
	localparam int BLOCK_B  = 4096;
	localparam int PER_BLK  = 128;
	localparam int NBLK     = 16;
	localparam int NSLOTS   = NBLK * PER_BLK;
	localparam logic [salb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [salb_pkg::STATUS_W-1:0] status;
		logic [salb_pkg::ADDR_W-1:0]   slot_address;
		logic                          is_live;
		logic [salb_pkg::LCOUNT_W-1:0] live_count;
		logic [salb_pkg::BCOUNT_W-1:0] blocks_committed;
	} alloc_result_t;

	// Allocator shadow model and queue of predicted results.
	class alloc_scoreboard;
		bit [NSLOTS-1:0]             live_bits;
		int                          link_next[NSLOTS];
		bit                          link_last[NSLOTS];
		int                          top;
		bit                          list_empty;
		int                          n_blocks;
		int                          n_live;
		logic [salb_pkg::ADDR_W-1:0] base;
		alloc_result_t               pending[$];
		int                          errors;

		function new();
			live_bits  = '0;
			list_empty = 1;
			top        = 0;
			n_blocks   = 0;
			n_live     = 0;
			base       = '0;
			errors     = 0;
			grow();
		endfunction

		function void push_free(int idx);
			link_next[idx] = top;
			link_last[idx] = list_empty;
			top            = idx;
			list_empty     = 0;
		endfunction

		function void grow();
			for (int s = 0; s < PER_BLK; s++)
				push_free(n_blocks * PER_BLK + s);
			n_blocks++;
		endfunction

		function bit find_slot(logic [salb_pkg::ADDR_W-1:0] a, output int idx);
			logic [salb_pkg::ADDR_W-1:0] off;
			logic [salb_pkg::ADDR_W-1:0] in_blk;
			off    = a - base;
			idx    = 0;
			if (off >= n_blocks * BLOCK_B) return 0;
			in_blk = off % BLOCK_B;
			if (in_blk % SLOT_B != 0 || in_blk >= PER_BLK * SLOT_B) return 0;
			idx = int'((off / BLOCK_B) * PER_BLK + in_blk / SLOT_B);
			return 1;
		endfunction

		function void note_request(logic [salb_pkg::OP_W-1:0] op,
				logic [salb_pkg::ADDR_W-1:0] a, logic [salb_pkg::SIZE_W-1:0] sz);
			alloc_result_t r;
			int idx;
			r.status = salb_pkg::ST_OK;
			r.slot_address = '0;
			r.is_live = 0;
			if (op == salb_pkg::OP_ALLOC) begin
				if (sz == 0) r.status = salb_pkg::ST_NULL;
				else if (sz > SLOT_B) r.status = salb_pkg::ST_BIG;
				else if (list_empty && n_blocks >= NBLK) r.status = salb_pkg::ST_FULL;
				else begin
					if (list_empty) grow();
					idx        = top;
					list_empty = link_last[idx];
					top        = link_next[idx];
					if (!live_bits[idx]) begin
						live_bits[idx] = 1;
						n_live++;
					end
					r.slot_address = base + (idx / PER_BLK) * BLOCK_B
						+ (idx % PER_BLK) * SLOT_B;
				end
			end else if (op == salb_pkg::OP_FREE) begin
				if (a == 0 || sz == 0) r.status = salb_pkg::ST_NULL;
				else if (sz > SLOT_B) r.status = salb_pkg::ST_BIG;
				else if (!find_slot(a, idx)) r.status = salb_pkg::ST_NOTSLOT;
				else begin
					if (live_bits[idx]) begin
						live_bits[idx] = 0;
						n_live--;
					end
					push_free(idx);
				end
			end else if (op == salb_pkg::OP_CONTAINS) begin
				if (find_slot(a, idx)) r.is_live = live_bits[idx];
				else r.status = salb_pkg::ST_NOTSLOT;
			end
			r.live_count       = salb_pkg::LCOUNT_W'(n_live);
			r.blocks_committed = salb_pkg::BCOUNT_W'(n_blocks);
			pending = {pending, r};
		endfunction

		function void check_result(alloc_result_t got);
			alloc_result_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d",
					$time, got.status);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
				errors++;
			end
			if (got.slot_address !== exp.slot_address) begin
				$display("%0t: slot_address expected %h actual %h", $time,
					exp.slot_address, got.slot_address);
				errors++;
			end
			if (got.is_live !== exp.is_live) begin
				$display("%0t: is_live expected %0d actual %0d", $time, exp.is_live, got.is_live);
				errors++;
			end
			if (got.live_count !== exp.live_count) begin
				$display("%0t: live_count expected %0d actual %0d", $time,
					exp.live_count, got.live_count);
				errors++;
			end
			if (got.blocks_committed !== exp.blocks_committed) begin
				$display("%0t: blocks_committed expected %0d actual %0d", $time,
					exp.blocks_committed, got.blocks_committed);
				errors++;
			end
		endfunction
	endclass

	logic                          clk = 0;
	logic                          arst_n = 0;
	logic                          start = 0;
	logic                          busy;
	logic [salb_pkg::OP_W-1:0]     operation = '0;
	logic [salb_pkg::ADDR_W-1:0]   address = '0;
	logic [salb_pkg::SIZE_W-1:0]   request_size = '0;
	logic                          cfg_we = 0;
	logic [salb_pkg::ADDR_W-1:0]   cfg_wdata = '0;
	logic                          done;
	logic [salb_pkg::STATUS_W-1:0] status;
	logic [salb_pkg::ADDR_W-1:0]   slot_address;
	logic                          is_live;
	logic [salb_pkg::LCOUNT_W-1:0] live_count;
	logic [salb_pkg::BCOUNT_W-1:0] blocks_committed;

	alloc_scoreboard sb = new();
	logic [salb_pkg::ADDR_W-1:0] handed_out[$];
	int burst_left = 0;

	always #5 clk = ~clk;

	slot_allocator_live_bitmap_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .address(address), .request_size(request_size),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .status(status),
		.slot_address(slot_address), .is_live(is_live), .live_count(live_count),
		.blocks_committed(blocks_committed)
	);

	// Check every result strobe; remember allocated addresses for later frees.
	always @(posedge clk) begin
		alloc_result_t got;
		if (arst_n && done) begin
			got.status           = status;
			got.slot_address     = slot_address;
			got.is_live          = is_live;
			got.live_count       = live_count;
			got.blocks_committed = blocks_committed;
			if (status == salb_pkg::ST_OK && slot_address != 0)
				handed_out = {handed_out, slot_address};
			sb.check_result(got);
		end
	end

	// One request transfer, with bursty gaps before it. Start stays high
	// between requests of a burst and drops only for a gap or a drain.
	task automatic send(logic [salb_pkg::OP_W-1:0] op, logic [salb_pkg::ADDR_W-1:0] a,
			logic [salb_pkg::SIZE_W-1:0] sz);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				start <= 0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		start        <= 1;
		operation    <= op;
		address      <= a;
		request_size <= sz;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(op, a, sz);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_base(logic [salb_pkg::ADDR_W-1:0] b);
		drain();
		cfg_we    <= 1;
		cfg_wdata <= b;
		@(posedge clk);
		cfg_we <= 0;
		sb.base = b;
		handed_out.delete();
	endtask

	function automatic logic [salb_pkg::ADDR_W-1:0] pick_addr();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5 && handed_out.size() != 0)
			return handed_out[$urandom_range(0, handed_out.size() - 1)];
		if (sel < 8)
			return sb.base + $urandom_range(0, NBLK - 1) * BLOCK_B
				+ $urandom_range(0, 130) * SLOT_B + ($urandom_range(0, 7) == 0 ? 4 : 0);
		return salb_pkg::ADDR_W'({$urandom, $urandom});
	endfunction

	function automatic logic [salb_pkg::SIZE_W-1:0] pick_size();
		unique case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(SLOT_B + 1, 100);
			2: return $urandom;
			default: return $urandom_range(1, SLOT_B);
		endcase
	endfunction

	// Directed cases, then random phases under several region bases.
	initial begin
		logic [salb_pkg::OP_W-1:0] op;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		set_base(48'd0);
		send(salb_pkg::OP_ALLOC, '0, 32'd0);
		send(salb_pkg::OP_ALLOC, '0, 32'd33);
		send(salb_pkg::OP_ALLOC, '0, 32'hFFFF_FFFF);
		send(salb_pkg::OP_ALLOC, '0, 32'd1);
		send(salb_pkg::OP_ALLOC, '0, 32'd32);
		send(salb_pkg::OP_CONTAINS, 48'd4064, '0);
		send(salb_pkg::OP_CONTAINS, 48'd0, '0);
		send(salb_pkg::OP_FREE, 48'd0, 32'd8);
		send(salb_pkg::OP_FREE, 48'd4064, 32'd0);
		send(salb_pkg::OP_FREE, 48'd4064, 32'd40);
		send(salb_pkg::OP_FREE, 48'd4065, 32'd8);
		send(salb_pkg::OP_FREE, 48'd4096, 32'd8);
		send(salb_pkg::OP_FREE, 48'hFFFF_FFFF_FFFF, 32'd8);
		send(salb_pkg::OP_FREE, 48'd4064, 32'd8);
		send(salb_pkg::OP_FREE, 48'd4064, 32'd8);
		send(salb_pkg::OP_CONTAINS, 48'd4064, '0);
		send(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send(salb_pkg::OP_CONTAINS, 48'd4096 - 16, '0);
		// A region base near the top of the address space wraps the offsets.
		set_base(48'hFFFF_FFFF_F000);
		for (int i = 0; i < 8; i++) send(salb_pkg::OP_ALLOC, '0, 32'd16);
		send(salb_pkg::OP_CONTAINS, 48'd0, '0);
		send(salb_pkg::OP_FREE, 48'hFFFF_FFFF_F020, 32'd32);
		for (int ph = 0; ph < 4; ph++) begin
			unique case (ph)
				0: set_base(48'h0000_1234_5000);
				1: set_base(48'd0);
				2: set_base(48'hFFFF_FFFF_FFFF);
				default: set_base(salb_pkg::ADDR_W'({$urandom, $urandom}));
			endcase
			for (int i = 0; i < 105; i++) begin
				op = ($urandom_range(0, 9) < 4) ? salb_pkg::OP_ALLOC
					: salb_pkg::OP_W'($urandom_range(0, 3));
				send(op, pick_addr(), pick_size());
			end
		end
		drain();
		if (sb.errors == 0)
			$display("PASS slot_allocator_live_bitmap_top");
		else
			$display("FAIL slot_allocator_live_bitmap_top");
		$finish;
	end

	// Run limit.
	initial begin
		#5000000;
		$display("FAIL slot_allocator_live_bitmap_top");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/salb_pkg.sv
hw/rtl/salb_ctrl.sv
hw/rtl/salb_dpath.sv
hw/rtl/slot_allocator_live_bitmap_top.sv
tb/testbench.sv
